### hdl/sbp_pkg.sv
//==============================================================================
// sbp_pkg
// Shared types and constants for the spanning tree BPDU frame parser.
//==============================================================================
`default_nettype none

package sbp_pkg;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  bpdu_kind;
        logic [63:0] sender_bridge;
        logic [63:0] root_bridge;
        logic [31:0] root_path_cost;
        logic [15:0] port_ident;
        logic [2:0]  port_state;
        logic        topo_change;
        logic [47:0] source_mac;
    } out_word_t;

    // classified BPDU handed from parser to output stage
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] sender_bridge;
        logic [63:0] root_bridge;
        logic [31:0] root_path_cost;
        logic [15:0] port_ident;
        logic        rstp_version;
        logic [7:0]  flags;
        logic [47:0] source_mac;
    } q_entry_t;

    localparam logic [1:0] KIND_CONFIG = 2'd0;
    localparam logic [1:0] KIND_RSTP   = 2'd1;
    localparam logic [1:0] KIND_TCN    = 2'd2;

    localparam logic [2:0] STATE_FORWARDING = 3'd0;
    localparam logic [2:0] STATE_LEARNING   = 3'd1;
    localparam logic [2:0] STATE_BLOCKING   = 3'd2;
    localparam logic [2:0] STATE_DISCARDING = 3'd3;
    localparam logic [2:0] STATE_TCN        = 3'd4;

    localparam logic [7:0] LLC_SAP       = 8'h42;
    localparam logic [7:0] LLC_CTRL      = 8'h03;
    localparam logic [7:0] BPDU_PROTOCOL = 8'h00;
    localparam logic [7:0] TYPE_CONFIG   = 8'h00;
    localparam logic [7:0] TYPE_RSTP     = 8'h02;
    localparam logic [7:0] TYPE_TCN      = 8'h80;
    localparam logic [7:0] VERSION_RSTP  = 8'h02;

    // byte offsets within the frame
    localparam logic [5:0] POS_SRC_FIRST  = 6'd6;
    localparam logic [5:0] POS_SRC_LAST   = 6'd11;
    localparam logic [5:0] POS_LLC_DSAP   = 6'd14;
    localparam logic [5:0] POS_LLC_SSAP   = 6'd15;
    localparam logic [5:0] POS_LLC_CTRL   = 6'd16;
    localparam logic [5:0] POS_PROTO_HI   = 6'd17;
    localparam logic [5:0] POS_PROTO_LO   = 6'd18;
    localparam logic [5:0] POS_VERSION    = 6'd19;
    localparam logic [5:0] POS_TYPE       = 6'd20;
    localparam logic [5:0] POS_FLAGS      = 6'd21;
    localparam logic [5:0] POS_ROOT_FIRST = 6'd22;
    localparam logic [5:0] POS_ROOT_LAST  = 6'd29;
    localparam logic [5:0] POS_COST_FIRST = 6'd30;
    localparam logic [5:0] POS_COST_LAST  = 6'd33;
    localparam logic [5:0] POS_BRG_FIRST  = 6'd34;
    localparam logic [5:0] POS_BRG_LAST   = 6'd41;
    localparam logic [5:0] POS_PORT_FIRST = 6'd42;
    localparam logic [5:0] POS_PORT_LAST  = 6'd43;
    localparam logic [5:0] POS_MAX        = 6'd63;

    // last-byte position of the shortest acceptable frames (21 and 52 bytes)
    localparam logic [5:0] POS_MIN_TCN    = 6'd20;
    localparam logic [5:0] POS_MIN_CONFIG = 6'd51;

    function automatic logic [7:0] dest_byte(input logic [2:0] i);
        logic [7:0] b;
        case (i)
            3'd0:    b = 8'h01;
            3'd1:    b = 8'h80;
            3'd2:    b = 8'hc2;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [2:0] rstp_port_state(input logic [7:0] f);
        logic [2:0] s;
        if (f[5]) begin
            s = STATE_FORWARDING;
        end else if (f[4]) begin
            s = STATE_LEARNING;
        end else if (f[3:2] == 2'b11) begin
            s = STATE_BLOCKING;
        end else begin
            s = STATE_DISCARDING;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

### hdl/sbp_front.sv
//==============================================================================
// sbp_front
// Byte parser: tracks position, checks header, collects BPDU fields and
// classifies the frame on its last byte.
//==============================================================================
`default_nettype none

module sbp_front
    import sbp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_data,
    output logic          q_push,
    output q_entry_t      q_entry,
    input  wire logic     q_full
);

    logic [5:0]  pos_reg,    pos_next;
    logic        hdr_ok_reg, hdr_ok_next;
    logic [47:0] src_reg,    src_next;
    logic [7:0]  ver_reg,    ver_next;
    logic [7:0]  type_reg,   type_next;
    logic [7:0]  flag_reg,   flag_next;
    logic [63:0] root_reg,   root_next;
    logic [31:0] cost_reg,   cost_next;
    logic [63:0] brg_reg,    brg_next;
    logic [15:0] port_reg,   port_next;

    logic       accept;
    logic [7:0] b;
    logic       mismatch;
    logic       hdr_ok_now;
    logic       is_tcn;
    logic       is_cfg;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.frame_byte;

    always_comb begin
        mismatch = 1'b0;
        if (pos_reg < POS_SRC_FIRST) begin
            mismatch = (b != dest_byte(pos_reg[2:0]));
        end else if (pos_reg == POS_LLC_DSAP || pos_reg == POS_LLC_SSAP) begin
            mismatch = (b != LLC_SAP);
        end else if (pos_reg == POS_LLC_CTRL) begin
            mismatch = (b != LLC_CTRL);
        end else if (pos_reg == POS_PROTO_HI || pos_reg == POS_PROTO_LO) begin
            mismatch = (b != BPDU_PROTOCOL);
        end
    end

    assign hdr_ok_now = hdr_ok_reg && !mismatch;

    always_comb begin
        src_next  = src_reg;
        ver_next  = ver_reg;
        type_next = type_reg;
        flag_next = flag_reg;
        root_next = root_reg;
        cost_next = cost_reg;
        brg_next  = brg_reg;
        port_next = port_reg;
        if (pos_reg >= POS_SRC_FIRST && pos_reg <= POS_SRC_LAST) begin
            src_next = {src_reg[39:0], b};
        end
        if (pos_reg == POS_VERSION) begin
            ver_next = b;
        end
        if (pos_reg == POS_TYPE) begin
            type_next = b;
        end
        if (pos_reg == POS_FLAGS) begin
            flag_next = b;
        end
        if (pos_reg >= POS_ROOT_FIRST && pos_reg <= POS_ROOT_LAST) begin
            root_next = {root_reg[55:0], b};
        end
        if (pos_reg >= POS_COST_FIRST && pos_reg <= POS_COST_LAST) begin
            cost_next = {cost_reg[23:0], b};
        end
        if (pos_reg >= POS_BRG_FIRST && pos_reg <= POS_BRG_LAST) begin
            brg_next = {brg_reg[55:0], b};
        end
        if (pos_reg >= POS_PORT_FIRST && pos_reg <= POS_PORT_LAST) begin
            port_next = {port_reg[7:0], b};
        end
    end

    always_comb begin
        if (s_data.last_byte) begin
            pos_next    = '0;
            hdr_ok_next = 1'b1;
        end else begin
            pos_next    = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 6'd1;
            hdr_ok_next = hdr_ok_now;
        end
    end

    // type byte is taken from the current byte when the frame ends on it
    assign is_tcn = hdr_ok_now && (pos_reg >= POS_MIN_TCN) && (type_next == TYPE_TCN);
    assign is_cfg = hdr_ok_now && (pos_reg >= POS_MIN_CONFIG)
                    && (type_next == TYPE_CONFIG || type_next == TYPE_RSTP);

    assign q_push = accept && s_data.last_byte && (is_tcn || is_cfg);

    always_comb begin
        q_entry.source_mac = src_reg;
        if (is_tcn) begin
            q_entry.kind           = KIND_TCN;
            q_entry.sender_bridge  = '0;
            q_entry.root_bridge    = '0;
            q_entry.root_path_cost = '0;
            q_entry.port_ident     = '0;
            q_entry.rstp_version   = 1'b0;
            q_entry.flags          = '0;
        end else begin
            q_entry.kind           = (type_next == TYPE_RSTP) ? KIND_RSTP : KIND_CONFIG;
            q_entry.sender_bridge  = brg_reg;
            q_entry.root_bridge    = root_reg;
            q_entry.root_path_cost = cost_reg;
            q_entry.port_ident     = port_reg;
            q_entry.rstp_version   = (ver_reg == VERSION_RSTP);
            q_entry.flags          = flag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            hdr_ok_reg <= 1'b1;
        end else if (accept) begin
            pos_reg    <= pos_next;
            hdr_ok_reg <= hdr_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            src_reg  <= src_next;
            ver_reg  <= ver_next;
            type_reg <= type_next;
            flag_reg <= flag_next;
            root_reg <= root_next;
            cost_reg <= cost_next;
            brg_reg  <= brg_next;
            port_reg <= port_next;
        end
    end

endmodule

`default_nettype wire

### hdl/sbp_queue.sv
//==============================================================================
// sbp_queue
// Two-entry queue of classified BPDUs between parser and output stage.
//==============================================================================
`default_nettype none

module sbp_queue
    import sbp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire q_entry_t wr_entry,
    output logic          full,
    input  wire logic     pop,
    output logic          not_empty,
    output q_entry_t      rd_entry
);

    q_entry_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rd_entry  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

### hdl/sbp_back.sv
//==============================================================================
// sbp_back
// Output stage: decodes port state and flag, holds the result word.
//==============================================================================
`default_nettype none

module sbp_back
    import sbp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     q_not_empty,
    input  wire q_entry_t q_entry,
    output logic          q_pop,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_word_t     m_data
);

    logic      valid_reg;
    out_word_t data_reg, data_next;

    assign q_pop   = q_not_empty && (!valid_reg || m_ready);
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_comb begin
        data_next.bpdu_kind      = q_entry.kind;
        data_next.sender_bridge  = q_entry.sender_bridge;
        data_next.root_bridge    = q_entry.root_bridge;
        data_next.root_path_cost = q_entry.root_path_cost;
        data_next.port_ident     = q_entry.port_ident;
        data_next.source_mac     = q_entry.source_mac;
        if (q_entry.kind == KIND_TCN) begin
            data_next.port_state  = STATE_TCN;
            data_next.topo_change = 1'b1;
        end else begin
            data_next.port_state  = q_entry.rstp_version ? rstp_port_state(q_entry.flags)
                                                         : STATE_FORWARDING;
            data_next.topo_change = q_entry.flags[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_ready) begin
            valid_reg <= q_not_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

### hdl/stp_bpdu_frame_parser.sv
//==============================================================================
// stp_bpdu_frame_parser
// Spanning tree BPDU parser: one Ethernet frame byte per word in, one
// record per valid Config, RSTP or TCN BPDU out.
//
// Input channel s_: frame bytes from the destination MAC onward, with
// last_byte marking the end of frame. One word is taken per clock while s_ready is high.
// Output channel m_: one word per valid BPDU, nothing for other frames.
// Result path: the record is written to the queue at the edge that accepts the
// last byte, then loaded into the output register, raising m_valid, once that
// register is empty or m_ready is high.
// Throughput: one byte per cycle while the queue is not full (s_ready high).
// Stall: a two-entry queue sits between parser and output register; with
// m_ready low, s_ready drops only once the queue holds two records, i.e.
// after three pending records.
// Reset (aresetn low, synchronous): byte position and header check are
// cleared, queue and output register emptied; the next byte starts a frame.
//==============================================================================
`default_nettype none

module stp_bpdu_frame_parser
    import sbp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_word_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_data
);

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_not_empty;
    q_entry_t q_wr_entry;
    q_entry_t q_rd_entry;

    sbp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_entry (q_wr_entry),
        .q_full  (q_full)
    );

    sbp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wr_entry  (q_wr_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rd_entry  (q_rd_entry)
    );

    sbp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_entry     (q_rd_entry),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

### hdl/sbp_checker.sv
//==============================================================================
// sbp_checker
// Port-level checks for the BPDU frame parser, bound to the top level.
//==============================================================================
`default_nettype none

module sbp_checker
    import sbp_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_word_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_word_t m_data
);

    // stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // a TCN record carries fixed fields
    a_tcn_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bpdu_kind == KIND_TCN |->
            m_data.port_state == STATE_TCN && m_data.topo_change
            && m_data.sender_bridge == '0 && m_data.root_path_cost == '0)
        else $error("bad TCN record");

    a_cfg_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bpdu_kind != KIND_TCN |-> m_data.port_state != STATE_TCN)
        else $error("TCN state on Config/RSTP record");

    // a fresh result follows an accepted end of frame
    a_out_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_data.last_byte, 2))
        else $error("result without end of frame");

    // input backpressure only after the output has stalled
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && $past(m_valid && !m_ready))
        else $error("s_ready low without output stall");

endmodule

bind stp_bpdu_frame_parser sbp_checker u_sbp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
